// ----- hw/rtl/sactc_pkg.sv -----
// Shared types and constants for the set-associative FIFO-replacement tag check.
`default_nettype none

package sactc_pkg;

  // Fixed widths of the transaction fields.
  localparam int ADDR_W    = 32;
  localparam int WAY_OUT_W = 3;
  localparam int COUNT_W   = 32;

  // Widest way index that any legal way count needs.
  localparam int MAX_WAY_W = 5;

  // Packed stream widths.
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Item kinds carried on the slave tuser bit.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_t;

  // Outcome of comparing one set row against a tag.
  typedef struct packed {
    logic                 hit;
    logic [MAX_WAY_W-1:0] way;
  } match_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sactc_tag_mem.sv -----
// Tag memory: one row per set holding every way's tag, synchronous read, per-way write.
`default_nettype none

module sactc_tag_mem #(
  parameter int SET_COUNT = 8,
  parameter int WAY_COUNT = 8,
  parameter int SET_IW    = 3,
  parameter int WAY_IW    = 3,
  parameter int TAG_W     = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [SET_IW-1:0]                 rd_set,
  output logic      [WAY_COUNT-1:0][TAG_W-1:0]   rd_row,
  input  wire logic                              wr_en,
  input  wire logic [SET_IW-1:0]                 wr_set,
  input  wire logic [WAY_IW-1:0]                 wr_way,
  input  wire logic [TAG_W-1:0]                  wr_tag
);

  logic [WAY_COUNT-1:0][TAG_W-1:0] mem [SET_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set][wr_way] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sactc_way_match.sv -----
// Compares every way of a set row against a tag and picks the lowest matching valid way.
`default_nettype none

module sactc_way_match #(
  parameter int WAY_COUNT = 8,
  parameter int TAG_W     = 25
) (
  input  wire logic [WAY_COUNT-1:0][TAG_W-1:0] row,
  input  wire logic [WAY_COUNT-1:0]            valid,
  input  wire logic [TAG_W-1:0]                tag,
  output sactc_pkg::match_t                    match
);

  always_comb begin
    match = '0;
    // Scan downward so the lowest numbered match wins.
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (valid[w] && (row[w] == tag)) begin
        match.hit = 1'b1;
        match.way = sactc_pkg::MAX_WAY_W'(w);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/set_assoc_cache_fifo_tag_check_top.sv -----
// Top level of the set-associative tag check with FIFO replacement and hit/miss counters.
// An accepted item's tag row is read on acceptance and compared in the check state; the result is
// loaded when the output register is free, and no new item is accepted before that load.
// A finished result waits in the output register while the next item is already accepted.
// Reset (rst, synchronous) invalidates every way and zeroes FIFO pointers and counters;
// the tag memory itself is not cleared since a tag is only compared under its valid bit.
`default_nettype none

module set_assoc_cache_fifo_tag_check_top #(
  parameter int ADDR_BITS   = 32,
  // SET_COUNT must be a power of two: the set index is taken straight from line bits.
  parameter int SET_COUNT   = 8,
  parameter int WAY_COUNT   = 8,
  parameter int OFFSET_BITS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // s_tdata: address[31:0]
  input  wire logic [sactc_pkg::S_DATA_W-1:0]     s_tdata,
  // s_tuser: mode[0] (0 = lookup, 1 = clear)
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // m_tdata: hit[0], way[3:1], hit_count[35:4], miss_count[67:36], zero fill[71:68]
  output logic [sactc_pkg::M_DATA_W-1:0]          m_tdata
);

  // Address split. Bits of the address port above ADDR_BITS are ignored.
  localparam int EFF_BITS = (ADDR_BITS < sactc_pkg::ADDR_W) ? ADDR_BITS : sactc_pkg::ADDR_W;
  localparam int SET_BITS = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
  localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_IW   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int TAG_RAW  = EFF_BITS - OFFSET_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam logic [sactc_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= sactc_pkg::ADDR_W) ? {sactc_pkg::ADDR_W{1'b1}}
                                     : sactc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [WAY_IW-1:0] WAY_LAST = WAY_IW'(WAY_COUNT - 1);

  // Control state.
  sactc_pkg::state_t state;
  logic              clr_q;
  logic [SET_IW-1:0] set_q;
  logic [TAG_W-1:0]  tag_q;

  // Per-entry valid bits and per-set FIFO pointers live in flip-flops so a clear is instant.
  logic [SET_COUNT-1:0][WAY_COUNT-1:0] valid;
  logic [SET_COUNT-1:0][WAY_IW-1:0]    fifo_ptr;

  logic [sactc_pkg::COUNT_W-1:0] hit_count;
  logic [sactc_pkg::COUNT_W-1:0] miss_count;

  // Output register.
  logic                           out_hit;
  logic [sactc_pkg::WAY_OUT_W-1:0] out_way;
  logic [sactc_pkg::COUNT_W-1:0]  out_hits;
  logic [sactc_pkg::COUNT_W-1:0]  out_misses;

  logic                                  in_fire;
  logic                                  load;
  logic [sactc_pkg::ADDR_W-1:0]          addr_m;
  logic [sactc_pkg::ADDR_W-1:0]          line;
  logic [sactc_pkg::ADDR_W-1:0]          tag_full;
  logic [SET_IW-1:0]                     set_in;
  logic [WAY_COUNT-1:0][TAG_W-1:0]       rd_row;
  sactc_pkg::match_t                     match;
  logic [WAY_IW-1:0]                     cur_ptr;
  logic [WAY_IW-1:0]                     res_way;
  logic                                  fill;

  assign s_tready = (state == sactc_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // The result may be loaded when the output register is empty or being emptied.
  assign load = (state == sactc_pkg::ST_CHECK) && (!m_tvalid || m_tready);

  assign addr_m   = s_tdata[sactc_pkg::ADDR_W-1:0] & ADDR_MASK;
  assign line     = addr_m >> OFFSET_BITS;
  assign tag_full = addr_m >> (OFFSET_BITS + SET_BITS);
  assign set_in   = (SET_COUNT == 1) ? '0 : line[SET_IW-1:0];

  // Tag row is read on acceptance and compared in the following cycle.
  sactc_tag_mem #(
    .SET_COUNT (SET_COUNT),
    .WAY_COUNT (WAY_COUNT),
    .SET_IW    (SET_IW),
    .WAY_IW    (WAY_IW),
    .TAG_W     (TAG_W)
  ) u_tag_mem (
    .clk    (clk),
    .rd_en  (in_fire),
    .rd_set (set_in),
    .rd_row (rd_row),
    .wr_en  (fill),
    .wr_set (set_q),
    .wr_way (cur_ptr),
    .wr_tag (tag_q)
  );

  sactc_way_match #(
    .WAY_COUNT (WAY_COUNT),
    .TAG_W     (TAG_W)
  ) u_way_match (
    .row   (rd_row),
    .valid (valid[set_q]),
    .tag   (tag_q),
    .match (match)
  );

  assign cur_ptr = fifo_ptr[set_q];
  // A lookup that misses fills the way under the set's FIFO pointer.
  assign fill    = load && !clr_q && !match.hit;
  assign res_way = match.hit ? match.way[WAY_IW-1:0] : cur_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sactc_pkg::ST_IDLE;
    end else begin
      unique case (state)
        sactc_pkg::ST_IDLE: begin
          if (in_fire) begin
            state <= sactc_pkg::ST_CHECK;
          end
        end
        sactc_pkg::ST_CHECK: begin
          if (load) begin
            state <= sactc_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= sactc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Item fields captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      clr_q <= (s_tuser == sactc_pkg::MODE_CLEAR);
      set_q <= set_in;
      tag_q <= tag_full[TAG_W-1:0];
    end
  end

  // Valid bits, FIFO pointers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      fifo_ptr   <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else if (load) begin
      if (clr_q) begin
        valid      <= '0;
        fifo_ptr   <= '0;
        hit_count  <= '0;
        miss_count <= '0;
      end else if (match.hit) begin
        if (hit_count != sactc_pkg::COUNT_MAX) begin
          hit_count <= hit_count + 1'b1;
        end
      end else begin
        valid[set_q][cur_ptr] <= 1'b1;
        fifo_ptr[set_q]       <= (cur_ptr == WAY_LAST) ? '0 : cur_ptr + 1'b1;
        if (miss_count != sactc_pkg::COUNT_MAX) begin
          miss_count <= miss_count + 1'b1;
        end
      end
    end
  end

  // Output register: the counts shown are those after this item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (clr_q) begin
        out_hit    <= 1'b0;
        out_way    <= '0;
        out_hits   <= '0;
        out_misses <= '0;
      end else begin
        out_hit    <= match.hit;
        out_way    <= sactc_pkg::WAY_OUT_W'(res_way);
        out_hits   <= (match.hit && hit_count != sactc_pkg::COUNT_MAX)
                      ? hit_count + 1'b1 : hit_count;
        out_misses <= (!match.hit && miss_count != sactc_pkg::COUNT_MAX)
                      ? miss_count + 1'b1 : miss_count;
      end
    end
  end

  assign m_tdata = {4'b0000, out_misses, out_hits, out_way, out_hit};

`ifndef SYNTHESIS
  // An accepted transaction blocks the input until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("input ready while an item is still being checked");

  // A new result only appears out of the check state.
  a_load_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == sactc_pkg::ST_CHECK))
    else $error("result presented without a tag check");

  // After a miss, the filled way is valid in its set.
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    fill |=> valid[$past(set_q)][$past(cur_ptr)])
    else $error("filled way not marked valid");

  // A clear result carries zero counts.
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (load && clr_q) |=> (out_hits == '0 && out_misses == '0 && !out_hit))
    else $error("clear result not zero");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_set_assoc_cache_fifo_tag_check_top.sv -----
// Self-checking testbench for the 8-set, 8-way FIFO-replacement tag check with hit/miss counters.
module tb_set_assoc_cache_fifo_tag_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sactc_pkg::*;

  // Geometry of the default build: 16-byte lines, 8 sets, 8 ways, 25-bit tags.
  localparam int SET_TOTAL    = 8;
  localparam int WAY_TOTAL    = 8;
  localparam int TAG_W        = 25;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 550;
  localparam int MAX_GAP      = 13;
  localparam int TAG_POOL     = 12;   // more tags than ways, so sets keep evicting
  localparam int PAUSE_AT     = 275;  // random item before which the source drains the block
  localparam int HOLD_AT      = 200;  // result count at which the sink holds off
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One result transaction, unpacked from m_tdata.
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
  } access_result_t;

  // A row of the directed table. Where typed is set, the result is written out by hand.
  typedef struct {
    logic           mode;
    logic [31:0]    address;
    bit             typed;
    access_result_t result;
  } directed_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  set_assoc_cache_fifo_tag_check_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow copy of the tag store, valid bits, FIFO pointers and counters.
  logic [TAG_W-1:0]   line_tag   [SET_TOTAL][WAY_TOTAL];
  logic               line_valid [SET_TOTAL][WAY_TOTAL];
  logic [2:0]         fill_ptr   [SET_TOTAL];
  logic [COUNT_W-1:0] hits_seen;
  logic [COUNT_W-1:0] misses_seen;

  // Results predicted for accepted transactions, oldest first.
  access_result_t pending_results [$];

  int error_count    = 0;
  int sent_count     = 0;
  int received_count = 0;
  int cycle_count    = 0;

  // The directed part. Hand-written results cover the start after reset, the extreme
  // addresses and the clears; the set 0 fill-and-evict sequence relies on the predictor.
  directed_row_t directed_rows [22] = '{
    // First access after reset misses and fills way 0 of set 0.
    '{MODE_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}},
    // Same line, highest offset: hit in way 0.
    '{MODE_LOOKUP, 32'h0000_000F, 1'b1, '{1'b1, 3'd0, 32'd1, 32'd1}},
    // All-ones address lands in set 7 with the largest tag.
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd1, 32'd2}},
    '{MODE_LOOKUP, 32'hFFFF_FFF0, 1'b1, '{1'b1, 3'd0, 32'd2, 32'd2}},
    // Tags 1..7 fill the rest of set 0, tag 8 wraps the FIFO pointer and evicts way 0.
    '{MODE_LOOKUP, 32'h0000_0080, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0100, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0180, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0200, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0280, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0300, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0380, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0400, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0005, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0089, 1'b0, '0},
    '{MODE_LOOKUP, 32'h0000_0070, 1'b0, '0},
    '{MODE_LOOKUP, 32'hAAAA_AAAA, 1'b0, '0},
    '{MODE_LOOKUP, 32'h5555_5555, 1'b0, '0},
    // A clear returns all zeros whatever address rides along with it.
    '{MODE_CLEAR,  32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}},
    // Back-to-back clears, then the cache starts over from way 0.
    '{MODE_CLEAR,  32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{MODE_CLEAR,  32'h1234_5678, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{MODE_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 3'd0, 32'd0, 32'd1}}
  };

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("set_assoc_cache_fifo_tag_check_top test failed");
    $finish;
  end

  // Applies one transaction to the shadow cache and returns the result it produces.
  function automatic access_result_t access_tag_store(logic mode, logic [31:0] address);
    access_result_t   res;
    logic [2:0]       set_idx;
    logic [TAG_W-1:0] tag;
    logic             found;
    logic [2:0]       way_idx;
    res = '0;
    if (mode == MODE_CLEAR) begin
      for (int s = 0; s < SET_TOTAL; s++) begin
        fill_ptr[s] = '0;
        for (int w = 0; w < WAY_TOTAL; w++) begin
          line_valid[s][w] = 1'b0;
        end
      end
      hits_seen   = '0;
      misses_seen = '0;
      return res;
    end
    set_idx = address[6:4];
    tag     = address[31:7];
    found   = 1'b0;
    way_idx = '0;
    // The lowest matching way wins.
    for (int w = 0; w < WAY_TOTAL; w++) begin
      if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        found   = 1'b1;
        way_idx = 3'(w);
      end
    end
    if (found) begin
      if (hits_seen != COUNT_MAX) hits_seen++;
    end else begin
      // Fill the way under the FIFO pointer; the 3-bit pointer wraps by itself.
      way_idx                     = fill_ptr[set_idx];
      line_tag[set_idx][way_idx]   = tag;
      line_valid[set_idx][way_idx] = 1'b1;
      fill_ptr[set_idx]           = way_idx + 3'd1;
      if (misses_seen != COUNT_MAX) misses_seen++;
    end
    res.hit        = found;
    res.way        = way_idx;
    res.hit_count  = hits_seen;
    res.miss_count = misses_seen;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Offers one transaction after a random gap, waits for the handshake and records the
  // expected result. Called at a falling edge, returns at a falling edge.
  task automatic send_access(input logic mode, input logic [31:0] address, input bit typed,
                             input access_result_t typed_result);
    int             gap;
    access_result_t predicted;
    // The first 30 of every 100 transactions go out back to back.
    gap = (sent_count % 100 < 30) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= address;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = access_tag_store(mode, address);
    pending_results.push_back(typed ? typed_result : predicted);
    sent_count++;
    @(negedge clk);
  endtask

  // Stops offering and waits until every outstanding result has been collected.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Source: reset, the directed table, then the random mix.
  initial begin : stimulus
    logic [TAG_W-1:0] tag_pool [TAG_POOL];
    logic [31:0]      address;
    int               pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = MODE_LOOKUP;
    s_tdata  = '0;
    // Reset leaves the cache in the same state as a clear.
    void'(access_tag_store(MODE_CLEAR, '0));
    // A small working set of tags, including both extremes, so that lines get reused.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].mode, directed_rows[i].address, directed_rows[i].typed,
                  directed_rows[i].result);
    end
    wait_for_drain();

    // Random part: mostly accesses to the working set, some fully random addresses as
    // noise, and an occasional clear.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_access(MODE_CLEAR, $urandom, 1'b0, '0);
      end else if (pick < 17) begin
        send_access(MODE_LOOKUP, $urandom, 1'b0, '0);
      end else begin
        address = {tag_pool[$urandom_range(0, TAG_POOL - 1)], 3'($urandom_range(0, 7)),
                   4'($urandom_range(0, 15))};
        send_access(MODE_LOOKUP, address, 1'b0, '0);
      end
    end

    // Let every result come back, then give the block a few quiet cycles.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("set_assoc_cache_fifo_tag_check_top test passed");
    end else begin
      $display("set_assoc_cache_fifo_tag_check_top test failed");
    end
    $finish;
  end

  // Sink: stalls at random, holds off once for a long stretch, and checks every result
  // transaction against the oldest pending expectation.
  initial begin : result_sink
    int             gap;
    access_result_t got;
    access_result_t want;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      // One long hold-off so the block fills up and pushes back on the source.
      if (received_count == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = (received_count % 90 < 25) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.hit        = m_tdata[0];
      got.way        = m_tdata[3:1];
      got.hit_count  = m_tdata[35:4];
      got.miss_count = m_tdata[67:36];
      received_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending: hit=%0b way=%0d",
                                  got.hit, got.way));
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
          report_mismatch($sformatf("result %0d hit: got %0b, expected %0b",
                                    received_count, got.hit, want.hit));
        if (got.way !== want.way)
          report_mismatch($sformatf("result %0d way: got %0d, expected %0d",
                                    received_count, got.way, want.way));
        if (got.hit_count !== want.hit_count)
          report_mismatch($sformatf("result %0d hit_count: got %0d, expected %0d",
                                    received_count, got.hit_count, want.hit_count));
        if (got.miss_count !== want.miss_count)
          report_mismatch($sformatf("result %0d miss_count: got %0d, expected %0d",
                                    received_count, got.miss_count, want.miss_count));
      end
      @(negedge clk);
    end
  end

endmodule

// ----- sim.f -----
hw/rtl/sactc_pkg.sv
hw/rtl/sactc_tag_mem.sv
hw/rtl/sactc_way_match.sv
hw/rtl/set_assoc_cache_fifo_tag_check_top.sv
dv/tb_set_assoc_cache_fifo_tag_check_top.sv
